// File: design/lru_frame_replacer_core_defines.svh
// ----------------------------------------------------------------------------
// LRU frame replacer assertion macros
// Implication checks clocked on clk with arst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_CORE_DEFINES_SVH
`define LRU_FRAME_REPLACER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfr: same-cycle check failed");
// next-cycle implication
`define LFR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfr: next-cycle check failed");
`else
`define LFR_ASSERT_NOW(label, ante, cons)
`define LFR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: design/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Request codes, field widths and internal action codes of the LRU replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

	localparam int REQ_W   = 2;
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;

	// frame_id reaches at most this many frames
	localparam int FRAME_SPAN = 1 << FRAME_W;

	localparam int S_TDATA_W = 8;   // frame_id, padded
	localparam int M_TDATA_W = 16;  // victim_frame, tracked_count, padded
	localparam int M_TUSER_W = 1;   // victim_valid

	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_VICTIM = 2'd0;
	localparam req_t REQ_PIN    = 2'd1;
	localparam req_t REQ_UNPIN  = 2'd2;

	typedef logic [2:0] act_t;

	localparam act_t ACT_NONE   = 3'd0;  // report only
	localparam act_t ACT_VICTIM = 3'd1;  // unlink oldest frame
	localparam act_t ACT_REMOVE = 3'd2;  // unlink named frame
	localparam act_t ACT_INSERT = 3'd3;  // append untracked frame
	localparam act_t ACT_MOVE   = 3'd4;  // unlink, then append

endpackage

`default_nettype wire

// File: design/lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_core
// Least-recently-used order over buffer frames, kept as a doubly linked list
// in two link RAMs with oldest/newest pointers and per-frame presence flops.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat fields (lowest bit first)
//  -------  ---  -----------------------------------------------------------
//  s_*      in   tuser: req_type[1:0]; tdata: frame_id[5:0], 2 pad bits
//  m_*      out  tuser: victim_valid; tdata: victim_frame[5:0],
//                tracked_count[12:6], 3 pad bits
//
//  At acceptance a request reads the next/prev link RAMs (registered read);
//  in S_LINK, with the result slot free, it does the unlink or append writes
//  and loads the result. Unpin of a tracked frame that is not the newest
//  unlinks in S_LINK and appends in S_ATTACH: each needs the RAM write ports.
//  The result register lets the next request be accepted while a result
//  waits; a stalled m_tready holds the sequencer before any state changes.
//  Reset clears presence flops, pointers and count; links need no clearing.
//
`default_nettype none
`include "lru_frame_replacer_core_defines.svh"

module lru_frame_replacer_core #(
	parameter int NUM_FRAMES = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lfr_pkg::S_TDATA_W-1:0] s_tdata,  // frame_id[5:0], pad[7:6]
	input  wire logic [lfr_pkg::REQ_W-1:0]     s_tuser,  // req_type[1:0]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [lfr_pkg::M_TDATA_W-1:0] m_tdata,  // victim_frame[5:0],
	                                                     // tracked_count[12:6], pad
	output logic      [lfr_pkg::M_TUSER_W-1:0] m_tuser   // victim_valid[0]
);

	import lfr_pkg::*;

	// frames above what frame_id can name are never used
	localparam int DEPTH   = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam logic [FRAME_W:0] DEPTH_LIM = (FRAME_W + 1)'(DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LINK   = 2'd1;
	localparam logic [1:0] S_ATTACH = 2'd2;

	logic [1:0]       state_q, state_d;
	act_t             act_q, act_d;
	logic [IDX_W-1:0] fidx_q, fidx_d;
	logic [IDX_W-1:0] oldest_q, oldest_d;
	logic [IDX_W-1:0] newest_q, newest_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [DEPTH-1:0] present_q, present_d;

	logic             out_valid_q;
	logic             out_vflag_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic [COUNT_W-1:0] out_count_q;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic             vflag_d;

	req_t             req_in;
	logic [FRAME_W-1:0] frame_in;
	logic [IDX_W-1:0] fidx_in;
	logic             in_range;
	logic             hit;

	// link RAM ports
	logic             nxt_we, prv_we;
	logic [IDX_W-1:0] nxt_waddr, prv_waddr;
	logic [IDX_W-1:0] nxt_wdata, prv_wdata;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] nxt_rd, prv_rd;

	logic             is_old, is_new;

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	assign req_in   = s_tuser;
	assign frame_in = s_tdata[FRAME_W-1:0];
	assign fidx_in  = frame_in[IDX_W-1:0];
	assign in_range = {1'b0, frame_in} < DEPTH_LIM;
	assign hit      = in_range && present_q[fidx_in];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Pick the action at acceptance; victim works on the oldest frame.
	always_comb begin
		act_d  = ACT_NONE;
		fidx_d = fidx_in;
		case (req_in)
			REQ_VICTIM: begin
				fidx_d = oldest_q;
				if (count_q != '0) begin
					act_d = ACT_VICTIM;
				end
			end
			REQ_PIN: begin
				if (hit) begin
					act_d = ACT_REMOVE;
				end
			end
			REQ_UNPIN: begin
				if (in_range && !hit) begin
					act_d = ACT_INSERT;
				end else if (hit && (fidx_in != newest_q)) begin
					act_d = ACT_MOVE;
				end
			end
			default: begin
				act_d = ACT_NONE;
			end
		endcase
	end

	// Read both links of the target frame in the accept cycle.
	assign rd_addr = fidx_d;

	lfr_ram #(
		.WIDTH(IDX_W),
		.DEPTH(DEPTH)
	) u_next_ram (
		.clk  (clk),
		.we   (nxt_we),
		.waddr(nxt_waddr),
		.wdata(nxt_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(nxt_rd)
	);

	lfr_ram #(
		.WIDTH(IDX_W),
		.DEPTH(DEPTH)
	) u_prev_ram (
		.clk  (clk),
		.we   (prv_we),
		.waddr(prv_waddr),
		.wdata(prv_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(prv_rd)
	);

	// End pointers stand in for the null links, so the RAMs hold no marker.
	assign is_old = (fidx_q == oldest_q);
	assign is_new = (fidx_q == newest_q);

	// ------------------------------------------------------------------
	// Sequencer: unlink / append and load the result
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		oldest_d  = oldest_q;
		newest_d  = newest_q;
		count_d   = count_q;
		present_d = present_q;
		nxt_we    = 1'b0;
		prv_we    = 1'b0;
		nxt_waddr = prv_rd;
		nxt_wdata = nxt_rd;
		prv_waddr = nxt_rd;
		prv_wdata = prv_rd;
		load_out  = 1'b0;
		vflag_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				// hold everything while the result slot is occupied
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					case (act_q)
						ACT_VICTIM: begin
							vflag_d           = 1'b1;
							present_d[fidx_q] = 1'b0;
							count_d           = count_q - 1'b1;
							oldest_d          = nxt_rd;
						end
						ACT_REMOVE: begin
							present_d[fidx_q] = 1'b0;
							count_d           = count_q - 1'b1;
							nxt_we            = !is_old && !is_new;
							prv_we            = !is_old && !is_new;
							if (is_old) begin
								oldest_d = nxt_rd;
							end
							if (is_new) begin
								newest_d = prv_rd;
							end
						end
						ACT_INSERT: begin
							present_d[fidx_q] = 1'b1;
							count_d           = count_q + 1'b1;
							newest_d          = fidx_q;
							if (count_q != '0) begin
								prv_we    = 1'b1;
								prv_waddr = fidx_q;
								prv_wdata = newest_q;
								nxt_we    = 1'b1;
								nxt_waddr = newest_q;
								nxt_wdata = fidx_q;
							end else begin
								oldest_d = fidx_q;
							end
						end
						ACT_MOVE: begin
							// unlink here, append next cycle; newest is not the frame
							load_out = 1'b0;
							state_d  = S_ATTACH;
							nxt_we   = !is_old;
							prv_we   = !is_old;
							if (is_old) begin
								oldest_d = nxt_rd;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			S_ATTACH: begin
				if (out_free) begin
					prv_we    = 1'b1;
					prv_waddr = fidx_q;
					prv_wdata = newest_q;
					nxt_we    = 1'b1;
					nxt_waddr = newest_q;
					nxt_wdata = fidx_q;
					newest_d  = fidx_q;
					load_out  = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_NONE;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			oldest_q  <= oldest_d;
			newest_q  <= newest_d;
			count_q   <= count_d;
			present_q <= present_d;
			if (accept) begin
				act_q <= act_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			fidx_q <= fidx_d;
		end
		if (load_out) begin
			out_vflag_q <= vflag_d;
			out_frame_q <= vflag_d ? FRAME_W'(fidx_q) : '0;
			out_count_q <= COUNT_W'(count_d);
		end
	end

	// ------------------------------------------------------------------
	// Result channel
	// ------------------------------------------------------------------
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_vflag_q;
	assign m_tdata  = {{(M_TDATA_W - FRAME_W - COUNT_W){1'b0}}, out_count_q, out_frame_q};

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`LFR_ASSERT_NOW(a_count_matches_marks, 1'b1, $countones(present_q) == int'(count_q))
	`LFR_ASSERT_NOW(a_ends_tracked, count_q != '0,
		present_q[oldest_q] && present_q[newest_q])
	`LFR_ASSERT_NXT(a_victim_cleared, (state_q == S_LINK) && out_free && (act_q == ACT_VICTIM),
		!present_q[$past(fidx_q)] && m_tvalid && m_tuser[0])

endmodule

`default_nettype wire

// File: design/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/lru_frame_replacer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_checker
// Watches both stream channels of the LRU frame replacer. It keeps its own
// copy of the oldest-to-newest frame list, predicts the result of every
// accepted request and compares each returned beat, field by field.
// ----------------------------------------------------------------------------
module lru_frame_replacer_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [lfr_pkg::S_TDATA_W-1:0] s_tdata,  // frame_id[5:0], pad[7:6]
	input  wire logic [lfr_pkg::REQ_W-1:0]     s_tuser,  // req_type[1:0]
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [lfr_pkg::M_TDATA_W-1:0] m_tdata,  // victim_frame[5:0],
	                                                     // tracked_count[12:6], pad
	input  wire logic [lfr_pkg::M_TUSER_W-1:0] m_tuser,  // victim_valid[0]
	output int                                 fail_count,
	output int                                 pending
);
	import lfr_pkg::*;

	localparam logic [6:0] NULL_LINK = 7'(FRAME_SPAN);

	typedef struct packed {
		logic               victim_valid;
		logic [FRAME_W-1:0] victim_frame;
		logic [COUNT_W-1:0] tracked_count;
	} lru_result_t;

	// shadow list state
	logic       lru_present [FRAME_SPAN];
	logic [6:0] lru_next    [FRAME_SPAN];
	logic [6:0] lru_prev    [FRAME_SPAN];
	logic [6:0] lru_oldest;
	logic [6:0] lru_newest;
	int         lru_count;

	lru_result_t expected_results[$];
	int          results_seen;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("lru check: result %0d %s: got %0d, expected %0d",
			results_seen, what, got, want);
		fail_count++;
	endtask

	function automatic void unlink_frame(input logic [5:0] f);
		logic [6:0] p;
		logic [6:0] n;
		p = lru_prev[f];
		n = lru_next[f];
		if (p != NULL_LINK) lru_next[p[5:0]] = n;
		else lru_oldest = n;
		if (n != NULL_LINK) lru_prev[n[5:0]] = p;
		else lru_newest = p;
	endfunction

	function automatic void append_newest(input logic [5:0] f);
		lru_prev[f] = lru_newest;
		lru_next[f] = NULL_LINK;
		if (lru_newest != NULL_LINK) lru_next[lru_newest[5:0]] = {1'b0, f};
		else lru_oldest = {1'b0, f};
		lru_newest = {1'b0, f};
	endfunction

	function automatic lru_result_t predict_request(input req_t rq, input logic [5:0] f);
		lru_result_t r;
		logic [6:0]  v;
		r = '0;
		case (rq)
			REQ_VICTIM: begin
				v = lru_oldest;
				if (lru_count != 0 && v != NULL_LINK && lru_present[v[5:0]]) begin
					unlink_frame(v[5:0]);
					lru_present[v[5:0]] = 1'b0;
					lru_count--;
					r.victim_valid = 1'b1;
					r.victim_frame = v[5:0];
				end
			end
			REQ_PIN: begin
				if (lru_present[f]) begin
					unlink_frame(f);
					lru_present[f] = 1'b0;
					if (lru_count != 0) lru_count--;
				end
			end
			REQ_UNPIN: begin
				if (!lru_present[f]) begin
					append_newest(f);
					lru_present[f] = 1'b1;
					lru_count++;
				end else if ({1'b0, f} != lru_newest) begin
					unlink_frame(f);
					append_newest(f);
				end
			end
			default: ;  // unused code: report only
		endcase
		r.tracked_count = 7'(lru_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lru_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < FRAME_SPAN; i++) begin
				lru_present[i] = 1'b0;
				lru_next[i]    = '0;
				lru_prev[i]    = '0;
			end
			lru_oldest = NULL_LINK;
			lru_newest = NULL_LINK;
			lru_count  = 0;
			expected_results.delete();
			results_seen = 0;
			fail_count   = 0;
		end else begin
			// retire the result first: a request taken at this edge cannot answer yet
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("with nothing outstanding, tdata", int'(m_tdata), -1);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser[0] !== want.victim_valid)
						report_mismatch("victim_valid", int'(m_tuser[0]),
							int'(want.victim_valid));
					if (m_tdata[5:0] !== want.victim_frame)
						report_mismatch("victim_frame", int'(m_tdata[5:0]),
							int'(want.victim_frame));
					if (m_tdata[12:6] !== want.tracked_count)
						report_mismatch("tracked_count", int'(m_tdata[12:6]),
							int'(want.tracked_count));
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_request(s_tuser, s_tdata[5:0]));
		end
		pending = expected_results.size();
	end

endmodule

// File: tb/sv/tb_lru_frame_replacer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_core
// Stimulus and verdict for the LRU frame replacer: a directed walk through
// empty-list, head, middle and tail cases, then random request segments that
// fill, churn and drain the list, with bursty requests and a stalling sink.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacer_core;
	import lfr_pkg::*;

	localparam int   CYCLE_LIMIT = 200000;
	localparam req_t REQ_UNUSED  = 2'd3;

	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // frame_id[5:0], pad[7:6]
	logic [REQ_W-1:0]     s_tuser;   // req_type[1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // victim_frame[5:0], tracked_count[12:6], pad
	logic [M_TUSER_W-1:0] m_tuser;   // victim_valid[0]

	int fail_count;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lru_frame_replacer_core #(
		.NUM_FRAMES(64)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lru_frame_replacer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** lru_frame_replacer_core: FAILED **");
			$finish;
		end
	end

	// Sink: ready runs and stall runs of random length, picked at random. Some ready
	// runs are long, so stretches of back-to-back results also occur.
	initial begin
		int run_left;
		int pick;
		logic ready_phase;
		m_tready    = 1'b0;
		run_left    = 0;
		ready_phase = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					ready_phase = 1'b1;
					run_left    = $urandom_range(20, 80);
				end else if (pick < 6) begin
					ready_phase = 1'b1;
					run_left    = $urandom_range(1, 8);
				end else begin
					ready_phase = 1'b0;
					run_left    = $urandom_range(1, 6);
				end
			end
			m_tready <= ready_phase;
			run_left--;
		end
	end

	// Send one request beat. Enter and leave at a falling edge; tvalid stays
	// high on return so the next beat of a burst follows without a bubble.
	task automatic issue(input req_t rq, input logic [FRAME_W-1:0] fid);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= rq;
		s_tdata  <= {2'b00, fid};
		// hold the beat until the block takes it
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop tvalid and hold off until every outstanding result is back.
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	// Random requests with a mix that pushes the list toward full, keeps it
	// churning, or empties it. Frames come from a small hot set a quarter of
	// the time so pins and refreshes hit tracked frames often.
	task automatic run_segment(input int items, input mix_t mix);
		int pick;
		int unpin_w;
		int pin_w;
		int victim_w;
		req_t rq;
		logic [FRAME_W-1:0] fid;
		case (mix)
			MIX_FILL:     begin unpin_w = 95; pin_w = 95;  victim_w = 99; end
			MIX_BALANCED: begin unpin_w = 45; pin_w = 70;  victim_w = 95; end
			default:      begin unpin_w = 20; pin_w = 50;  victim_w = 95; end
		endcase
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < unpin_w)       rq = REQ_UNPIN;
			else if (pick < pin_w)    rq = REQ_PIN;
			else if (pick < victim_w) rq = REQ_VICTIM;
			else                      rq = REQ_UNUSED;
			fid = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom_range(0, 7))
			                                  : FRAME_W'($urandom_range(0, 63));
			issue(rq, fid);
		end
	endtask

	// Unpin every frame once, in shuffled order: the list ends up full.
	task automatic fill_all_frames();
		int order[FRAME_SPAN];
		int j;
		int t;
		for (int i = 0; i < FRAME_SPAN; i++) order[i] = i;
		for (int i = FRAME_SPAN - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < FRAME_SPAN; i++) issue(REQ_UNPIN, FRAME_W'(order[i]));
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_VICTIM;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// ---- directed: empty list, then head / middle / tail of a short list
		issue(REQ_VICTIM, 6'd0);    // evict from empty list
		issue(REQ_UNUSED, 6'd63);   // unused code on empty list
		issue(REQ_PIN,    6'd0);    // pin of untracked frame
		issue(REQ_UNPIN,  6'd0);    // first insert
		issue(REQ_UNPIN,  6'd63);   // list: 0 63
		issue(REQ_UNPIN,  6'd0);    // refresh oldest -> 63 0
		issue(REQ_UNPIN,  6'd0);    // refresh newest: no change
		issue(REQ_UNPIN,  6'd21);
		issue(REQ_UNPIN,  6'd42);   // 63 0 21 42
		issue(REQ_UNPIN,  6'd63);   // refresh oldest -> 0 21 42 63
		issue(REQ_UNPIN,  6'd21);   // refresh middle -> 0 42 63 21
		issue(REQ_PIN,    6'd42);   // remove middle
		issue(REQ_PIN,    6'd0);    // remove oldest
		issue(REQ_PIN,    6'd21);   // remove newest
		issue(REQ_PIN,    6'd21);   // already gone
		issue(REQ_VICTIM, 6'd42);   // evicts 63, list empty
		issue(REQ_VICTIM, 6'd63);   // empty again
		issue(REQ_UNUSED, 6'd0);
		issue(REQ_UNPIN,  6'd42);
		issue(REQ_UNUSED, 6'd42);   // unused code with a tracked frame
		issue(REQ_PIN,    6'd42);   // remove sole entry
		issue(REQ_VICTIM, 6'd0);
		pause_until_drained();

		// ---- random: full list, churn, drain, near-full, churn, drain
		fill_all_frames();
		run_segment(120, MIX_BALANCED);
		pause_until_drained();
		run_segment(100, MIX_DRAIN);
		run_segment(150, MIX_FILL);
		pause_until_drained();
		run_segment(100, MIX_BALANCED);
		run_segment(66, MIX_DRAIN);

		// let the last results land, then let the block idle before the verdict
		pause_until_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("** lru_frame_replacer_core: PASSED **");
		end else begin
			$display("** lru_frame_replacer_core: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/lfr_pkg.sv
design/lfr_ram.sv
design/lru_frame_replacer_core.sv
tb/sv/lru_frame_replacer_checker.sv
tb/sv/tb_lru_frame_replacer_core.sv
